// File: rtl/core/btb_pkg.sv
package btb_pkg;

   localparam int BtbEntries       = 32;
   localparam int CountersPerTable = 256;
   localparam int SlotW            = $clog2(BtbEntries);
   localparam int CtrW             = $clog2(CountersPerTable);
   localparam int EntryCtrW        = SlotW + CtrW;
   localparam int ShareLsb         = 2;
   localparam int ShareMid         = 16;
   localparam logic [1:0] Wnt      = 2'd1;
   localparam logic [1:0] St       = 2'd3;

   localparam logic OpPredict = 1'b0;
   localparam logic OpUpdate  = 1'b1;

   localparam logic [1:0] ShareNone   = 2'd0;
   localparam logic [1:0] ShareXorLsb = 2'd1;
   localparam logic [1:0] ShareXorMid = 2'd2;

   localparam logic [2:0] CsrBtbIndexBits = 3'd0;
   localparam logic [2:0] CsrHistoryBits  = 3'd1;
   localparam logic [2:0] CsrTagBits      = 3'd2;
   localparam logic [2:0] CsrUseGlobalHist = 3'd3;
   localparam logic [2:0] CsrUseGlobalTbl = 3'd4;
   localparam logic [2:0] CsrShareMode    = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WRITE,
      ST_WIPE,
      ST_INIT
   } state_type;

endpackage

// File: rtl/core/btb_two_level_branch_predictor_core.sv
// Two-level branch predictor with a direct-mapped branch target buffer.
// Request channel: start with opcode (predict or update), pc, target_pc,
// taken and predicted_dst; a request is taken when start is high and busy
// is low. Every request gives one response, shown for one cycle with
// rsp_valid high in the write state, after the lookup state; the receiver must
// take it, it cannot stall.
// The lookup state uses the entry read issued at acceptance to form the
// counter index and issues the counter read; the write state forms the
// prediction, writes back the entry and the trained counter, and drives
// the response. busy is high in both states, so no new request is taken
// until the block is back in idle. An update whose tag misses adds a wipe
// of that entry's 256-counter row, one counter per cycle, with busy high.
// Configuration: csr_valid/csr_ready with csr_index and csr_data; csr_ready
// is high only while idle. Reset clears statistics and shared history, then
// a clearing pass sets every counter to weakly not taken and every entry to
// tag 0, target 0, history 0; busy stays high meanwhile.
module btb_two_level_branch_predictor_core
   import btb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_target_pc,
   input  logic        req_taken,
   input  logic [31:0] req_predicted_dst,
   output logic        rsp_valid,
   output logic        rsp_predict_taken,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_flush,
   output logic [31:0] rsp_branch_count,
   output logic [31:0] rsp_flush_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration
   logic [2:0] btb_index_bits_ff;
   logic [3:0] history_bits_ff;
   logic [4:0] tag_bits_ff;
   logic       use_ghist_ff;
   logic       use_gtbl_ff;
   logic [1:0] share_mode_ff;

   // memories
   logic [29:0] tag_mem    [BtbEntries];
   logic [31:0] target_mem [BtbEntries];
   logic [7:0]  hist_mem   [BtbEntries];
   logic [1:0]  ectr_mem   [BtbEntries*CountersPerTable];
   logic [1:0]  gctr_mem   [CountersPerTable];

   // address of the clearing pass (reset) and of the row wipe (tag miss)
   logic [EntryCtrW-1:0] clr_addr_ff;

   state_type state_ff, state_in;

   logic        op_ff, tk_ff;
   logic [31:0] pc_ff, tgt_ff, pdst_ff;
   logic [7:0]  ghist_ff;
   logic [31:0] branches_ff, flushes_ff;

   logic [29:0] tag_rd;
   logic [31:0] target_rd;
   logic [7:0]  hist_rd;
   logic [1:0]  ectr_rd, gctr_rd;

   logic        accept;
   logic        is_update;
   logic [SlotW-1:0] slot_req;

   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign is_update = (op_ff == OpUpdate);

   function automatic logic [SlotW-1:0] slot_f(input logic [31:0] pc, input logic [2:0] nb);
      logic [31:0] m;
      m = (32'd1 << nb) - 32'd1;
      return SlotW'((pc >> 2) & m);
   endfunction

   assign slot_req = slot_f(req_pc, btb_index_bits_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         btb_index_bits_ff <= '0;
         history_bits_ff   <= 4'd1;
         tag_bits_ff       <= '0;
         use_ghist_ff      <= 1'b0;
         use_gtbl_ff       <= 1'b0;
         share_mode_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrBtbIndexBits:  btb_index_bits_ff <= csr_data[2:0];
            CsrHistoryBits:   history_bits_ff   <= csr_data[3:0];
            CsrTagBits:       tag_bits_ff       <= csr_data[4:0];
            CsrUseGlobalHist: use_ghist_ff      <= csr_data[0];
            CsrUseGlobalTbl:  use_gtbl_ff       <= csr_data[0];
            CsrShareMode:     share_mode_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // lookup-cycle computation
   logic [SlotW-1:0] slot;
   logic [29:0] tag;
   logic [7:0]  hmask, hist_used, hidx;
   logic [CtrW-1:0] ci;
   logic        hit;
   logic        fl;
   logic [1:0]  ctr, ctr_new;
   logic [31:0] fall;
   logic [3:0]  hb;
   logic [4:0]  tb;
   logic [29:0] tmask;
   logic [7:0]  hist_new;

   // counter index and miss flag, held for the write cycle and the wipe
   logic [CtrW-1:0] ci_ff;
   logic            miss_ff;

   always_comb begin
      slot   = slot_f(pc_ff, btb_index_bits_ff);
      tb     = (tag_bits_ff > 5'd30) ? 5'd30 : tag_bits_ff;
      tmask  = 30'((32'd1 << tb) - 32'd1);
      tag    = pc_ff[31:2] & tmask;
      hit    = (tag_rd == tag);
      hb     = (history_bits_ff == 4'd0) ? 4'd1 :
               ((history_bits_ff > 4'd8) ? 4'd8 : history_bits_ff);
      hmask  = 8'((9'd1 << hb) - 9'd1);
      hist_used = use_ghist_ff ? ghist_ff : hist_rd;
      // a missing update starts its entry history over
      if (is_update && !hit && !use_ghist_ff) hist_used = 8'd0;
      hidx = hist_used & hmask;
      case (share_mode_ff)
         ShareXorLsb: hidx = hidx ^ pc_ff[ShareLsb+7:ShareLsb];
         ShareXorMid: hidx = hidx ^ pc_ff[ShareMid+7:ShareMid];
         default:     hidx = hidx;
      endcase
      hidx = hidx & hmask;
      ci   = CtrW'(hidx);
      fall = pc_ff + 32'd4;
      fl   = tk_ff ? (pdst_ff != tgt_ff) : (pdst_ff != fall);
      hist_new = ((hist_used << 1) | {7'd0, tk_ff}) & hmask;
   end

   // counter read result; a missing update sees its row as freshly wiped
   always_comb begin
      if (use_gtbl_ff)
         ctr = gctr_rd;
      else
         ctr = miss_ff ? Wnt : ectr_rd;
      if (tk_ff) ctr_new = (ctr < St) ? ctr + 2'd1 : ctr;
      else       ctr_new = (ctr != 2'd0) ? ctr - 2'd1 : ctr;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_WRITE;
         ST_WRITE:  state_in = miss_ff ? ST_WIPE : ST_IDLE;
         ST_WIPE:   if (clr_addr_ff[CtrW-1:0] == '1) state_in = ST_IDLE;
         ST_INIT:   if (clr_addr_ff == '1) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_WRITE);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else       state_ff <= state_in;
   end

   // advance the clearing address; restart it before each row wipe
   always_ff @(posedge clock) begin
      if (reset)
         clr_addr_ff <= '0;
      else if (state_ff == ST_WRITE)
         clr_addr_ff <= '0;
      else if (state_ff == ST_INIT || state_ff == ST_WIPE)
         clr_addr_ff <= clr_addr_ff + EntryCtrW'(1);
   end

   // request capture, entry read, counter read
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         pc_ff   <= req_pc;
         tgt_ff  <= req_target_pc;
         tk_ff   <= req_taken;
         pdst_ff <= req_predicted_dst;
         tag_rd    <= tag_mem[slot_req];
         target_rd <= target_mem[slot_req];
         hist_rd   <= hist_mem[slot_req];
      end
      if (state_ff == ST_LOOKUP) begin
         ci_ff   <= ci;
         miss_ff <= is_update && !hit;
         gctr_rd <= gctr_mem[ci];
         ectr_rd <= ectr_mem[{slot, ci}];
      end
   end

   // memory writes: clearing pass, row wipe, write back
   always_ff @(posedge clock) begin
      if (state_ff == ST_INIT) begin
         ectr_mem[clr_addr_ff] <= Wnt;
         if (clr_addr_ff < EntryCtrW'(CountersPerTable))
            gctr_mem[clr_addr_ff[CtrW-1:0]] <= Wnt;
         if (clr_addr_ff < EntryCtrW'(BtbEntries)) begin
            tag_mem[clr_addr_ff[SlotW-1:0]]    <= '0;
            target_mem[clr_addr_ff[SlotW-1:0]] <= '0;
            hist_mem[clr_addr_ff[SlotW-1:0]]   <= '0;
         end
      end else if (state_ff == ST_WIPE) begin
         // keep the trained counter when the row itself was trained
         ectr_mem[{slot, clr_addr_ff[CtrW-1:0]}] <=
            (!use_gtbl_ff && clr_addr_ff[CtrW-1:0] == ci_ff) ? ctr_new : Wnt;
      end else if (state_ff == ST_WRITE && is_update) begin
         tag_mem[slot]    <= tag;
         target_mem[slot] <= tgt_ff;
         if (!use_ghist_ff) hist_mem[slot] <= hist_new;
         else if (miss_ff) hist_mem[slot] <= 8'd0;
         if (use_gtbl_ff) gctr_mem[ci_ff] <= ctr_new;
         else             ectr_mem[{slot, ci_ff}] <= ctr_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ghist_ff     <= '0;
         branches_ff  <= '0;
         flushes_ff   <= '0;
      end else if (state_ff == ST_WRITE && is_update) begin
         branches_ff <= branches_ff + 32'd1;
         if (fl) flushes_ff <= flushes_ff + 32'd1;
         if (use_ghist_ff) ghist_ff <= hist_new;
      end
   end

   // response, driven straight from the write cycle
   logic ptk;
   assign ptk = !is_update && hit && (ctr > Wnt);
   assign rsp_predict_taken = ptk;
   assign rsp_next_pc       = is_update ? 32'd0 : (ptk ? target_rd : fall);
   assign rsp_flush         = is_update && fl;
   assign rsp_branch_count  = branches_ff + {31'd0, is_update};
   assign rsp_flush_count   = flushes_ff + {31'd0, is_update && fl};

   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid) else $error("response not two cycles after request");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_update |=> branches_ff == $past(branches_ff) + 32'd1)
      else $error("branch count not advanced");
   a_predict_noflush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_update |-> !rsp_flush) else $error("flush on predict");

endmodule

// File: tb/btb_two_level_branch_predictor_core_tb.sv
module btb_two_level_branch_predictor_core_tb;
   import btb_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [31:0] req_pc;
   logic [31:0] req_target_pc;
   logic        req_taken;
   logic [31:0] req_predicted_dst;
   logic        rsp_valid;
   logic        rsp_predict_taken;
   logic [31:0] rsp_next_pc;
   logic        rsp_flush;
   logic [31:0] rsp_branch_count;
   logic [31:0] rsp_flush_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   btb_two_level_branch_predictor_core u_dut (.*);

   // One expected response per request.
   typedef struct packed {
      logic        predict_taken;
      logic [31:0] next_pc;
      logic        flush;
      logic [31:0] branch_count;
      logic [31:0] flush_count;
   } verdict_type;

   // Shadow copy of the predictor state.
   logic [2:0]  cfg_index_bits;
   logic [3:0]  cfg_history_bits;
   logic [4:0]  cfg_tag_bits;
   logic        cfg_global_hist;
   logic        cfg_global_tbl;
   logic [1:0]  cfg_share;
   logic [29:0] shadow_tag [BtbEntries];
   logic [31:0] shadow_target [BtbEntries];
   logic [7:0]  shadow_hist [BtbEntries];
   logic [7:0]  shadow_ghist;
   logic [1:0]  shadow_ctr [BtbEntries][CountersPerTable];
   logic [1:0]  shadow_gctr [CountersPerTable];
   logic [31:0] shadow_branches;
   logic [31:0] shadow_flushes;

   verdict_type pending_verdicts[$];
   int unsigned errors;
   int unsigned cycle_count;
   int unsigned requests_sent;
   int unsigned responses_seen;
   bit          idle_enable;

   // Clock: period 8.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("[btb_two_level_branch_predictor_core] ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] history_mask();
      int n;
      n = cfg_history_bits;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      return 8'((1 << n) - 1);
   endfunction

   function automatic logic [29:0] branch_tag(logic [31:0] pc);
      int n;
      logic [31:0] m;
      n = (cfg_tag_bits > 30) ? 30 : cfg_tag_bits;
      m = (32'd1 << n) - 32'd1;
      return 30'((pc >> 2) & m);
   endfunction

   function automatic int branch_slot(logic [31:0] pc);
      logic [31:0] m;
      m = (32'd1 << cfg_index_bits) - 32'd1;
      return int'(((pc >> 2) & m) % BtbEntries);
   endfunction

   function automatic int pattern_index(int slot, logic [31:0] pc);
      logic [7:0] h;
      logic [7:0] m;
      m = history_mask();
      h = (cfg_global_hist ? shadow_ghist : shadow_hist[slot]) & m;
      if (cfg_share == ShareXorLsb) h = h ^ pc[ShareLsb +: 8];
      else if (cfg_share == ShareXorMid) h = h ^ pc[ShareMid +: 8];
      h = h & m;
      return int'(h) % CountersPerTable;
   endfunction

   // Advance the shadow state by one request and return its response.
   function automatic verdict_type predict_branch(logic op, logic [31:0] pc, logic [31:0] tgt,
                                                  logic tk, logic [31:0] pdst);
      verdict_type v;
      int slot;
      int ci;
      logic [29:0] tag;
      logic [1:0] c;
      logic [31:0] fall;
      fall = pc + 32'd4;
      slot = branch_slot(pc);
      tag  = branch_tag(pc);
      v = '0;
      if (op == OpPredict) begin
         v.next_pc = fall;
         if (shadow_tag[slot] == tag) begin
            ci = pattern_index(slot, pc);
            c = cfg_global_tbl ? shadow_gctr[ci] : shadow_ctr[slot][ci];
            if (c > Wnt) begin
               v.predict_taken = 1'b1;
               v.next_pc = shadow_target[slot];
            end
         end
      end else begin
         v.flush = tk ? (pdst != tgt) : (pdst != fall);
         shadow_branches++;
         if (v.flush) shadow_flushes++;
         if (shadow_tag[slot] != tag) begin
            shadow_hist[slot] = '0;
            for (int i = 0; i < CountersPerTable; i++) shadow_ctr[slot][i] = Wnt;
         end
         shadow_tag[slot] = tag;
         shadow_target[slot] = tgt;
         ci = pattern_index(slot, pc);
         c = cfg_global_tbl ? shadow_gctr[ci] : shadow_ctr[slot][ci];
         if (tk) begin
            if (c < St) c++;
         end else if (c > 0) begin
            c--;
         end
         if (cfg_global_tbl) shadow_gctr[ci] = c;
         else shadow_ctr[slot][ci] = c;
         if (cfg_global_hist) shadow_ghist = ((shadow_ghist << 1) | tk) & history_mask();
         else shadow_hist[slot] = ((shadow_hist[slot] << 1) | tk) & history_mask();
      end
      v.branch_count = shadow_branches;
      v.flush_count = shadow_flushes;
      return v;
   endfunction

   // Compare each response against the oldest pending expectation.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         responses_seen <= responses_seen + 1;
         if (pending_verdicts.size() == 0) begin
            errors++;
            $display("%0t: response exp none got next_pc=%h", $time, rsp_next_pc);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_predict_taken !== want.predict_taken) begin
               errors++;
               $display("%0t: predict_taken exp %b got %b", $time,
                        want.predict_taken, rsp_predict_taken);
            end
            if (rsp_next_pc !== want.next_pc) begin
               errors++;
               $display("%0t: next_pc exp %h got %h", $time, want.next_pc, rsp_next_pc);
            end
            if (rsp_flush !== want.flush) begin
               errors++;
               $display("%0t: flush exp %b got %b", $time, want.flush, rsp_flush);
            end
            if (rsp_branch_count !== want.branch_count) begin
               errors++;
               $display("%0t: branch_count exp %0d got %0d", $time,
                        want.branch_count, rsp_branch_count);
            end
            if (rsp_flush_count !== want.flush_count) begin
               errors++;
               $display("%0t: flush_count exp %0d got %0d", $time,
                        want.flush_count, rsp_flush_count);
            end
         end
      end
   end

   // Drop start for a random burst now and then.
   task automatic idle_gap();
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Send one request and wait for it to be accepted; start stays high.
   task automatic send_request(logic op, logic [31:0] pc, logic [31:0] tgt, logic tk,
                               logic [31:0] pdst);
      idle_gap();
      req_opcode        <= op;
      req_pc            <= pc;
      req_target_pc     <= tgt;
      req_taken         <= tk;
      req_predicted_dst <= pdst;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // Predict at the accepting edge, before the response can show up.
      pending_verdicts.push_back(predict_branch(op, pc, tgt, tk, pdst));
      requests_sent++;
   endtask

   // Drain: drop start, wait until nothing is pending, then a few more cycles.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one config register; valid stays high for the next write.
   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CsrBtbIndexBits:  cfg_index_bits   = val[2:0];
         CsrHistoryBits:   cfg_history_bits = val[3:0];
         CsrTagBits:       cfg_tag_bits     = val[4:0];
         CsrUseGlobalHist: cfg_global_hist  = val[0];
         CsrUseGlobalTbl:  cfg_global_tbl   = val[0];
         CsrShareMode:     cfg_share        = val[1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [2:0] ib, logic [3:0] hb, logic [4:0] tb,
                                 logic gh, logic gt, logic [1:0] sm);
      drain();
      write_csr(CsrBtbIndexBits, 32'(ib));
      write_csr(CsrHistoryBits, 32'(hb));
      write_csr(CsrTagBits, 32'(tb));
      write_csr(CsrUseGlobalHist, 32'(gh));
      write_csr(CsrUseGlobalTbl, 32'(gt));
      write_csr(CsrShareMode, 32'(sm));
      csr_valid <= 1'b0;
   endtask

   // Directed: reset-state hits, field extremes, tag misses, flushes.
   task automatic test_directed();
      send_request(OpPredict, 32'h0000_0000, 32'h0, 1'b0, 32'h0);
      send_request(OpPredict, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
      send_request(OpUpdate, 32'h0000_0010, 32'hFFFF_FFFF, 1'b1, 32'h0);
      send_request(OpUpdate, 32'h0000_0010, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_request(OpPredict, 32'h0000_0010, 32'h0, 1'b0, 32'h0);
      send_request(OpUpdate, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0000_0003);
      send_request(OpUpdate, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'hFFFF_FFFF);
      apply_settings(3'd5, 4'd8, 5'd30, 1'b0, 1'b0, ShareXorLsb);
      send_request(OpUpdate, 32'h1234_5678, 32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF);
      send_request(OpUpdate, 32'h1234_5678, 32'hDEAD_BEEF, 1'b1, 32'h0);
      send_request(OpPredict, 32'h1234_5678, 32'h0, 1'b0, 32'h0);
      // Same slot, different tag: row and history get cleared.
      send_request(OpUpdate, 32'h9234_5678, 32'h0000_1000, 1'b0, 32'h9234_567C);
      send_request(OpPredict, 32'h1234_5678, 32'h0, 1'b0, 32'h0);
      // Out-of-range settings: history 0 and 15, tag 31, share mode 3, index 7.
      apply_settings(3'd7, 4'd0, 5'd31, 1'b1, 1'b1, 2'd3);
      send_request(OpUpdate, 32'hFFFF_FFFC, 32'hAAAA_5555, 1'b1, 32'h0);
      send_request(OpPredict, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
      apply_settings(3'd0, 4'd15, 5'd0, 1'b1, 1'b0, ShareXorMid);
      send_request(OpUpdate, 32'h5555_0000, 32'h0, 1'b1, 32'h0);
      send_request(OpPredict, 32'h5555_0000, 32'h0, 1'b0, 32'h0);
   endtask

   // Random: train a small working set of branches, then probe it.
   task automatic test_random(int unsigned n_items);
      logic [31:0] pcs [8];
      logic [31:0] tgts [8];
      int k;
      logic tk;
      logic [31:0] pc;
      for (int i = 0; i < 8; i++) begin
         pcs[i]  = $urandom;
         tgts[i] = $urandom;
      end
      for (int unsigned n = 0; n < n_items; n++) begin
         k = $urandom_range(0, 7);
         pc = ($urandom_range(0, 9) == 0) ? $urandom : pcs[k];
         // Biased outcomes so counters saturate both ways.
         tk = ($urandom_range(0, 3) != 0) ^ k[0];
         if ($urandom_range(0, 1))
            send_request(OpPredict, pc, $urandom, 1'($urandom_range(0, 1)), $urandom);
         else
            send_request(OpUpdate, pc, tgts[k], tk,
                         $urandom_range(0, 1) ? (tk ? tgts[k] : pc + 32'd4) : $urandom);
      end
   endtask

   // Run random traffic under a sweep of settings.
   task automatic test_settings_sweep();
      apply_settings(3'd0, 4'd1, 5'd0, 1'b0, 1'b0, ShareNone);
      test_random(150);
      apply_settings(3'd5, 4'd8, 5'd30, 1'b1, 1'b1, ShareXorLsb);
      test_random(200);
      apply_settings(3'd3, 4'd4, 5'd6, 1'b0, 1'b1, ShareXorMid);
      test_random(200);
      apply_settings(3'd2, 4'd2, 5'd2, 1'b1, 1'b0, ShareNone);
      test_random(200);
      for (int p = 0; p < 5; p++) begin
         apply_settings(3'($urandom), 4'($urandom), 5'($urandom), 1'($urandom),
                        1'($urandom), 2'($urandom));
         test_random(150);
      end
      // Last part: no idle gaps.
      idle_enable = 1'b0;
      apply_settings(3'd4, 4'd6, 5'd12, 1'b0, 1'b0, ShareXorLsb);
      test_random(200);
   endtask

   initial begin
      errors = 0;
      cycle_count = 0;
      requests_sent = 0;
      responses_seen = 0;
      idle_enable = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = 1'b0;
      req_pc = '0;
      req_target_pc = '0;
      req_taken = 1'b0;
      req_predicted_dst = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg_index_bits = 3'd0;
      cfg_history_bits = 4'd1;
      cfg_tag_bits = 5'd0;
      cfg_global_hist = 1'b0;
      cfg_global_tbl = 1'b0;
      cfg_share = ShareNone;
      shadow_ghist = '0;
      shadow_branches = '0;
      shadow_flushes = '0;
      for (int s = 0; s < BtbEntries; s++) begin
         shadow_tag[s] = '0;
         shadow_target[s] = '0;
         shadow_hist[s] = '0;
         for (int i = 0; i < CountersPerTable; i++) shadow_ctr[s][i] = Wnt;
      end
      for (int i = 0; i < CountersPerTable; i++) shadow_gctr[i] = Wnt;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings_sweep();
      drain();
      $display("Sent %0d requests (predicts and updates) over 14 predictor settings,", requests_sent);
      $display("checked %0d responses.", responses_seen);
      if (errors == 0)
         $display("[btb_two_level_branch_predictor_core] OK");
      else
         $display("[btb_two_level_branch_predictor_core] ERROR");
      $finish;
   end

endmodule
